// ===== rtl/rvm_pkg.sv =====
// shared types and constants of the register machine instruction executor
package rvm_pkg;

	localparam int unsigned PROGRAM_WORDS = 1024;
	localparam int unsigned REG_COUNT     = 11;
	localparam int unsigned REG_IDX_W     = 4;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned ADDR_W        = 10;
	localparam int unsigned NEXT_W        = 11;
	localparam int unsigned HP_W          = 10;
	localparam int unsigned CHOICE_W      = 2;
	localparam int unsigned S_TDATA_W     = 120;
	localparam int unsigned M_TDATA_W     = 16;

	// register file indices
	localparam logic [REG_IDX_W-1:0] REG_R0 = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_R1 = 4'd1;
	localparam logic [REG_IDX_W-1:0] REG_R2 = 4'd2;
	localparam logic [REG_IDX_W-1:0] REG_C0 = 4'd3;
	localparam logic [REG_IDX_W-1:0] REG_E0 = 4'd5;
	localparam logic [REG_IDX_W-1:0] REG_I0 = 4'd7;
	localparam logic [REG_IDX_W-1:0] REG_I1 = 4'd8;
	localparam logic [REG_IDX_W-1:0] REG_O0 = 4'd9;
	localparam logic [REG_IDX_W-1:0] REG_T0 = 4'd10;

	localparam logic [NEXT_W-1:0] END_ADDR = NEXT_W'(PROGRAM_WORDS);

	typedef enum logic [4:0] {
		OP_INC   = 5'd0,
		OP_DEC   = 5'd1,
		OP_INCEQ = 5'd2,
		OP_DECEQ = 5'd3,
		OP_ADD   = 5'd4,
		OP_SUB   = 5'd5,
		OP_MUL   = 5'd6,
		OP_STORE = 5'd7,
		OP_MOVE  = 5'd8,
		OP_LABEL = 5'd9,
		OP_JMP   = 5'd10,
		OP_JMPEQ = 5'd11,
		OP_JMPNE = 5'd12,
		OP_JMPGT = 5'd13,
		OP_JMPLT = 5'd14,
		OP_CMP   = 5'd15,
		OP_RET   = 5'd16
	} opcode_t;

endpackage

// ===== rtl/register_vm_instruction_execute.sv =====
// top level: register machine instruction executor with register file and flags
//
//  channel  | group                     | request contents
//  ---------+---------------------------+-----------------------------------------
//  input    | s_tvalid s_tready s_tdata | one fetched instruction, s_tuser = first
//           | s_tuser                   |   of run
//  output   | m_tvalid m_tready m_tdata | next address and choice, m_tlast = stop
//           | m_tlast                   |
//
// one instruction per cycle while the output is not stalled: an input register,
// one pass of decode, alu and register file update, and an output register
// the register file and flags are written as an instruction leaves the input
// register, so the next instruction already sees them
// reset clears the register file, flags and both valid stages
// the input side stalls only while a result waits in the output register
// and the input register is also full
module register_vm_instruction_execute (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// opcode[4:0] dest_reg[8:5] src_reg[12:9] immediate[44:13]
	// instr_address[54:45] jump_target[64:55] own_hp[74:65] enemy_hp[84:75]
	// tick[116:85] zero[119:117]
	input  logic [rvm_pkg::S_TDATA_W-1:0]     s_tdata,
	// first_of_run[0]
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// next_address[10:0] choice[12:11] zero[15:13]
	output logic [rvm_pkg::M_TDATA_W-1:0]     m_tdata,
	// stop
	output logic                              m_tlast
);

	localparam int unsigned W  = rvm_pkg::WORD_W;
	localparam int unsigned RC = rvm_pkg::REG_COUNT;
	localparam int unsigned IW = rvm_pkg::REG_IDX_W;
	localparam int unsigned AW = rvm_pkg::ADDR_W;
	localparam int unsigned NW = rvm_pkg::NEXT_W;
	localparam int unsigned HW = rvm_pkg::HP_W;
	localparam int unsigned CW = rvm_pkg::CHOICE_W;

	// input stage
	logic                  valid_s1;
	logic                  first_s1;
	rvm_pkg::opcode_t      opcode_s1;
	logic [IW-1:0]         dest_s1;
	logic [IW-1:0]         src_s1;
	logic [W-1:0]          imm_s1;
	logic [AW-1:0]         addr_s1;
	logic [AW-1:0]         target_s1;
	logic [HW-1:0]         own_s1;
	logic [HW-1:0]         enemy_s1;
	logic [W-1:0]          tick_s1;

	// architectural state
	logic [W-1:0]          rf_q [RC];
	logic                  flag_eq_q;
	logic                  flag_lt_q;
	logic                  flag_gt_q;

	// output register
	logic                  out_valid_q;
	logic [NW-1:0]         next_addr_q;
	logic [CW-1:0]         choice_q;
	logic                  stop_q;

	logic                  out_free;
	logic                  advance;
	logic                  in_fire;

	logic [W-1:0]          eff [RC];
	logic [W-1:0]          rf_nx [RC];
	logic                  flag_eq_nx;
	logic                  flag_lt_nx;
	logic                  flag_gt_nx;
	logic [W-1:0]          step_v;
	logic                  step_en;
	logic                  store_en;
	logic                  move_en;
	logic [W-1:0]          src_val;
	logic                  jump;
	logic [1:0]            ilen;
	logic [NW-1:0]         seq_next;
	logic [NW-1:0]         raw_next;
	logic [NW-1:0]         next_addr;
	logic                  stop;
	logic [CW-1:0]         choice;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			first_s1  <= s_tuser[0];
			opcode_s1 <= rvm_pkg::opcode_t'(s_tdata[4:0]);
			dest_s1   <= s_tdata[8:5];
			src_s1    <= s_tdata[12:9];
			imm_s1    <= s_tdata[44:13];
			addr_s1   <= s_tdata[54:45];
			target_s1 <= s_tdata[64:55];
			own_s1    <= s_tdata[74:65];
			enemy_s1  <= s_tdata[84:75];
			tick_s1   <= s_tdata[116:85];
		end
	end

	// register view after run start and tick load
	always_comb begin
		for (int k = 0; k < RC; k++) begin
			eff[k] = first_s1 ? '0 : rf_q[k];
		end
		if (first_s1) begin
			eff[rvm_pkg::REG_C0] = W'(own_s1);
			eff[rvm_pkg::REG_E0] = W'(enemy_s1);
		end
		eff[rvm_pkg::REG_T0] = tick_s1;
	end

	assign src_val = (src_s1 < IW'(RC)) ? eff[src_s1] : '0;

	always_comb begin
		step_en    = 1'b0;
		step_v     = W'(1);
		store_en   = 1'b0;
		move_en    = 1'b0;
		jump       = 1'b0;
		stop       = 1'b0;
		ilen       = 2'd1;
		flag_eq_nx = flag_eq_q;
		flag_lt_nx = flag_lt_q;
		flag_gt_nx = flag_gt_q;
		for (int k = 0; k < RC; k++) begin
			rf_nx[k] = eff[k];
		end
		unique case (opcode_s1)
			rvm_pkg::OP_INC: begin
				step_en = 1'b1;
				ilen    = 2'd2;
			end
			rvm_pkg::OP_DEC: begin
				step_en = 1'b1;
				step_v  = '1;
				ilen    = 2'd2;
			end
			rvm_pkg::OP_INCEQ: begin
				step_en = flag_eq_q;
				ilen    = 2'd2;
			end
			rvm_pkg::OP_DECEQ: begin
				step_en = flag_eq_q;
				step_v  = '1;
				ilen    = 2'd2;
			end
			rvm_pkg::OP_ADD: begin
				rf_nx[rvm_pkg::REG_O0] = eff[rvm_pkg::REG_I0] + eff[rvm_pkg::REG_I1];
			end
			rvm_pkg::OP_SUB: begin
				rf_nx[rvm_pkg::REG_O0] = eff[rvm_pkg::REG_I0] - eff[rvm_pkg::REG_I1];
			end
			rvm_pkg::OP_MUL: begin
				rf_nx[rvm_pkg::REG_O0] = eff[rvm_pkg::REG_I0] * eff[rvm_pkg::REG_I1];
			end
			rvm_pkg::OP_STORE: begin
				store_en = 1'b1;
				ilen     = 2'd3;
			end
			rvm_pkg::OP_MOVE: begin
				move_en = 1'b1;
				ilen    = 2'd3;
			end
			rvm_pkg::OP_LABEL: begin
				ilen = 2'd2;
			end
			rvm_pkg::OP_JMP: begin
				jump = 1'b1;
				ilen = 2'd2;
			end
			rvm_pkg::OP_JMPEQ: begin
				jump = flag_eq_q;
				ilen = 2'd2;
			end
			rvm_pkg::OP_JMPNE: begin
				jump = !flag_eq_q;
				ilen = 2'd2;
			end
			rvm_pkg::OP_JMPGT: begin
				jump = flag_gt_q;
				ilen = 2'd2;
			end
			rvm_pkg::OP_JMPLT: begin
				jump = flag_lt_q;
				ilen = 2'd2;
			end
			rvm_pkg::OP_CMP: begin
				flag_eq_nx = eff[rvm_pkg::REG_I0] == eff[rvm_pkg::REG_I1];
				flag_lt_nx = $signed(eff[rvm_pkg::REG_I0]) < $signed(eff[rvm_pkg::REG_I1]);
				flag_gt_nx = $signed(eff[rvm_pkg::REG_I0]) > $signed(eff[rvm_pkg::REG_I1]);
			end
			rvm_pkg::OP_RET: begin
				stop = 1'b1;
			end
			default: begin
			end
		endcase
		// each register updates itself when it is the target
		for (int k = 0; k < RC; k++) begin
			if (dest_s1 == IW'(k)) begin
				if (step_en) begin
					rf_nx[k] = eff[k] + step_v;
				end else if (store_en) begin
					rf_nx[k] = imm_s1;
				end else if (move_en) begin
					rf_nx[k] = src_val;
				end
			end
		end
	end

	assign seq_next  = NW'(addr_s1) + NW'(ilen);
	assign raw_next  = jump ? (NW'(target_s1) + NW'(1)) : seq_next;
	assign next_addr = (raw_next > rvm_pkg::END_ADDR) ? rvm_pkg::END_ADDR : raw_next;

	// r0 in 0..2 as a signed value, else zero
	assign choice = (rf_nx[rvm_pkg::REG_R0][W-1:CW] == '0 &&
			rf_nx[rvm_pkg::REG_R0][CW-1:0] != '1) ? rf_nx[rvm_pkg::REG_R0][CW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RC; k++) begin
				rf_q[k] <= '0;
			end
			flag_eq_q <= 1'b0;
			flag_lt_q <= 1'b0;
			flag_gt_q <= 1'b0;
		end else if (advance) begin
			for (int k = 0; k < RC; k++) begin
				rf_q[k] <= rf_nx[k];
			end
			flag_eq_q <= flag_eq_nx;
			flag_lt_q <= flag_lt_nx;
			flag_gt_q <= flag_gt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_addr_q <= next_addr;
			choice_q    <= choice;
			stop_q      <= stop;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, choice_q, next_addr_q};
	assign m_tlast  = stop_q;

endmodule

// ===== rtl/rvm_checker.sv =====
// port-level checks of the instruction executor, bound to the top level
module rvm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [rvm_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [0:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rvm_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output request changed while stalled");

	// next address never runs past the end of the program
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:0] <= rvm_pkg::END_ADDR)
		else $error("next address beyond program end");

	// choice is clamped to 0..2 and padding stays zero
	a_choice_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[12:11] != 2'b11 && m_tdata[15:13] == 3'b000)
		else $error("choice out of range or padding set");

	// input only backs up behind a waiting result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// an accepted request is followed by a valid result at the output
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##1 m_tvalid)
		else $error("accepted request produced no result");

endmodule

bind register_vm_instruction_execute rvm_checker u_rvm_checker (.*);
